// ===== rtl/core/tgarle_pkg.sv =====
package tgarle_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RLE_ENABLED = 1'd1;

    localparam logic [2:0] PIXEL_BYTES_RESET = 3'd3;
    localparam logic       RLE_ENABLED_RESET = 1'b1;

    localparam logic [7:0] LOW7_MASK = 8'h7f;

    // size code is bytes per pixel minus one
    localparam logic [1:0] SIZE_CODE_3 = 2'd2;
    localparam logic [1:0] SIZE_CODE_4 = 2'd3;

    // one queued beat as classified by the front end
    typedef struct packed {
        logic       clear;      // header: drop any partial pixel
        logic       done;       // this byte completes a pixel
        logic [1:0] lane;       // byte lane within the pixel
        logic [1:0] size_code;
        logic [7:0] data;
        logic [7:0] rep;
    } token_t;

    function automatic logic [1:0] size_code_of(input logic [2:0] pixel_bytes);
        logic [1:0] code;
        if (pixel_bytes == 3'd0) begin
            code = 2'd0;
        end else if (pixel_bytes > 3'd4) begin
            code = SIZE_CODE_4;
        end else begin
            code = 2'(pixel_bytes - 3'd1);
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// TGA run-length pixel decoder.
// s_* : one byte of image data per beat (valid/ready).
// m_* : one decoded pixel per beat with its repeat count 1..128; a run packet
//       gives one beat carrying the whole count, literal pixels carry 1.
//       Pixels of 3 or 4 bytes leave in R,G,B(,A) order, R in bits 7:0.
// cfg_we/cfg_addr/cfg_wdata: register 0 = bytes per pixel, 1 = run-length
//       enable. Write only while the decoder is idle.
// Throughput: one byte per cycle while the queue has room, including header bytes.
// Path: the beat carrying a pixel's last byte is registered in the queue between
//       the packet parser and the pixel assembler, which loads the pixel into
//       the output register once the beat is at the head and m_* can take it.
// Stall: the output register holds while m_ready is low; the parser keeps
//       taking bytes until the queue (QUEUE_DEPTH beats) fills, then s_ready
//       drops. Bytes that do not finish a pixel still drain while stalled.
// Reset (synchronous, aresetn low): 3 bytes per pixel, run-length on, the
//       parser awaits a packet header, queue and output empty.
module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [31:0]                        m_pixel,
    output logic [7:0]                         m_repeat_res,
    input  logic                               cfg_we,
    input  logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_addr,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [2:0]         pixel_bytes_reg;
    logic               rle_enabled_reg;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    tgarle_pkg::token_t in_tok;
    tgarle_pkg::token_t head_tok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_bytes_reg <= tgarle_pkg::PIXEL_BYTES_RESET;
            rle_enabled_reg <= tgarle_pkg::RLE_ENABLED_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                tgarle_pkg::REG_PIXEL_BYTES: pixel_bytes_reg <= cfg_wdata;
                tgarle_pkg::REG_RLE_ENABLED: rle_enabled_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    tgarle_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .size_code   (tgarle_pkg::size_code_of(pixel_bytes_reg)),
        .rle_enabled (rle_enabled_reg),
        .q_full      (q_full),
        .push        (push),
        .tok         (in_tok)
    );

    tgarle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (in_tok),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_tok (head_tok)
    );

    tgarle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .tok          (head_tok),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel      (m_pixel),
        .m_repeat_res (m_repeat_res)
    );

endmodule

// ===== rtl/core/tgarle_front.sv =====
module tgarle_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic [1:0]          size_code,
    input  logic                rle_enabled,
    input  logic                q_full,
    output logic                push,
    output tgarle_pkg::token_t  tok
);

    logic       expect_header_reg, expect_header_next;
    logic       run_packet_reg, run_packet_next;
    logic [7:0] pixels_left_reg, pixels_left_next;
    logic [1:0] byte_pos_reg, byte_pos_next;
    logic       is_header;
    logic       complete;
    logic [7:0] pl_dec;

    assign s_ready   = !q_full;
    assign push      = s_valid && s_ready;
    assign is_header = rle_enabled && expect_header_reg;
    assign complete  = byte_pos_reg >= size_code;
    assign pl_dec    = pixels_left_reg - 8'd1;

    always_comb begin
        expect_header_next = expect_header_reg;
        run_packet_next    = run_packet_reg;
        pixels_left_next   = pixels_left_reg;
        byte_pos_next      = byte_pos_reg;
        tok.clear     = is_header;
        tok.done      = 1'b0;
        tok.lane      = byte_pos_reg;
        tok.size_code = size_code;
        tok.data      = s_data_byte;
        tok.rep       = 8'd1;
        if (is_header) begin
            pixels_left_next   = (s_data_byte & tgarle_pkg::LOW7_MASK) + 8'd1;
            run_packet_next    = s_data_byte[7];
            expect_header_next = 1'b0;
            byte_pos_next      = 2'd0;
        end else if (!complete) begin
            byte_pos_next = byte_pos_reg + 2'd1;
        end else begin
            tok.done      = 1'b1;
            byte_pos_next = 2'd0;
            if (rle_enabled) begin
                if (run_packet_reg) begin
                    tok.rep            = pixels_left_reg;
                    pixels_left_next   = 8'd0;
                    expect_header_next = 1'b1;
                end else begin
                    pixels_left_next = pl_dec;
                    if (pl_dec == 8'd0) begin
                        expect_header_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            pixels_left_reg   <= 8'd0;
            byte_pos_reg      <= 2'd0;
        end else if (push) begin
            expect_header_reg <= expect_header_next;
            run_packet_reg    <= run_packet_next;
            pixels_left_reg   <= pixels_left_next;
            byte_pos_reg      <= byte_pos_next;
        end
    end

    // a packet in progress always has pixels to come
    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        !expect_header_reg |-> pixels_left_reg != 8'd0)
        else $error("packet open with no pixels left");

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pixels_left_reg <= 8'd128)
        else $error("pixel count beyond packet size");

endmodule

// ===== rtl/core/tgarle_queue.sv =====
module tgarle_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tgarle_pkg::token_t  push_tok,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output tgarle_pkg::token_t  head_tok
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    tgarle_pkg::token_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full     = count_reg == (AW+1)'(DEPTH);
    assign empty    = count_reg == '0;
    assign head_tok = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/tgarle_back.sv =====
module tgarle_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  tgarle_pkg::token_t  tok,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_pixel,
    output logic [7:0]          m_repeat_res
);

    logic [31:0] asm_reg, asm_next;
    logic [31:0] merged;
    logic [31:0] pix;
    logic        m_valid_reg;
    logic [31:0] pixel_reg;
    logic [7:0]  rep_reg;
    logic        load;

    assign pop  = !q_empty && (!tok.done || !m_valid_reg || m_ready);
    assign load = pop && tok.done;

    always_comb begin
        merged = tok.clear ? 32'd0 : asm_reg;
        if (!tok.clear) begin
            for (int i = 0; i < 4; i++) begin
                if (tok.lane == 2'(i)) begin
                    merged[8*i +: 8] = tok.data;
                end
            end
        end
        asm_next = tok.done ? 32'd0 : merged;
    end

    // B,G,R(,A) -> R,G,B(,A) for the wide formats
    always_comb begin
        pix = merged;
        if (tok.size_code == tgarle_pkg::SIZE_CODE_4) begin
            pix = {merged[31:24], merged[7:0], merged[15:8], merged[23:16]};
        end else if (tok.size_code == tgarle_pkg::SIZE_CODE_3) begin
            pix = {8'd0, merged[7:0], merged[15:8], merged[23:16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asm_reg     <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                asm_reg <= asm_next;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pixel_reg <= pix;
            rep_reg   <= tok.rep;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel      = pixel_reg;
    assign m_repeat_res = rep_reg;

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("completed pixel not presented");

    a_rep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (rep_reg != 8'd0 && rep_reg <= 8'd128))
        else $error("repeat count out of range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  rep;
    } pixel_beat_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [tgarle_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [tgarle_pkg::CFG_DATA_W-1:0]  value;
        logic [7:0]                         data;
        logic                               typed;
        logic [31:0]                        exp_pixel;
        logic [7:0]                         exp_rep;
    } row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [7:0]                         s_data_byte = 8'h00;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [31:0]                        m_pixel;
    logic [7:0]                         m_repeat_res;
    logic                               cfg_we = 1'b0;
    logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_addr = '0;
    logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // decoder shadow: configuration and packet state
    logic [2:0]  bytes_per_pixel = tgarle_pkg::PIXEL_BYTES_RESET;
    logic        rle_on = tgarle_pkg::RLE_ENABLED_RESET;
    logic        await_header = 1'b1;
    logic        run_pkt = 1'b0;
    logic [7:0]  pixels_to_go = 8'd0;
    logic [1:0]  lane_pos = 2'd0;
    logic [31:0] pixel_acc = 32'd0;

    pixel_beat_t pending_pixels[$];
    int          mismatch_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    row_t directed_rows [28] = '{
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h81, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h11, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h22, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h33, 1'b1, 32'h00112233, 8'd2},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'hff, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'hff, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'hff, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'hff, 1'b1, 32'h00ffffff, 8'd128},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h00, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h00, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h00, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h00, 1'b1, 32'h00000000, 8'd1},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h01, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h80, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h01, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'hfe, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h7f, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'hc3, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h3c, 1'b0, 32'h0,        8'd0},
        '{ROW_CFG,  tgarle_pkg::REG_PIXEL_BYTES, 3'd4, 8'h00, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h80, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h01, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h02, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h03, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'h04, 1'b0, 32'h0,        8'd0},
        '{ROW_CFG,  tgarle_pkg::REG_RLE_ENABLED, 3'd0, 8'h00, 1'b0, 32'h0,        8'd0},
        '{ROW_CFG,  tgarle_pkg::REG_PIXEL_BYTES, 3'd1, 8'h00, 1'b0, 32'h0,        8'd0},
        '{ROW_BYTE, tgarle_pkg::REG_PIXEL_BYTES, 3'd0, 8'ha5, 1'b1, 32'h000000a5, 8'd1}
    };

    // first random phases sweep the sizes, out-of-range codes included
    logic [2:0] size_plan [10] = '{3'd1, 3'd2, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6, 3'd3, 3'd4, 3'd1};
    logic       rle_plan  [10] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    tga_rle_pixel_decoder DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel      (m_pixel),
        .m_repeat_res (m_repeat_res),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic decode_tga_byte(input logic [7:0] b, output bit emitted,
                                   output pixel_beat_t beat);
        logic [2:0]  size;
        logic [31:0] pix;
        emitted = 1'b0;
        beat = '0;
        size = (bytes_per_pixel == 3'd0) ? 3'd1 :
               (bytes_per_pixel > 3'd4) ? 3'd4 : bytes_per_pixel;
        if (rle_on && await_header) begin
            pixels_to_go = (b & tgarle_pkg::LOW7_MASK) + 8'd1;
            run_pkt = b[7];
            await_header = 1'b0;
            lane_pos = 2'd0;
            pixel_acc = 32'd0;
        end else begin
            pixel_acc[lane_pos*8 +: 8] = b;
            if ({1'b0, lane_pos} + 3'd1 < size) begin
                lane_pos = lane_pos + 2'd1;
            end else begin
                pix = pixel_acc;
                // B,G,R(,A) in, R,G,B(,A) out
                if (size >= 3'd3) begin
                    pix = {pixel_acc[31:24], pixel_acc[7:0], pixel_acc[15:8], pixel_acc[23:16]};
                end
                if (size == 3'd3) begin
                    pix[31:24] = 8'h00;
                end
                beat.pixel = pix;
                beat.rep = 8'd1;
                if (rle_on) begin
                    if (run_pkt) begin
                        beat.rep = pixels_to_go;
                        pixels_to_go = 8'd0;
                        await_header = 1'b1;
                    end else begin
                        pixels_to_go = pixels_to_go - 8'd1;
                        if (pixels_to_go == 8'd0) begin
                            await_header = 1'b1;
                        end
                    end
                end
                lane_pos = 2'd0;
                pixel_acc = 32'd0;
                emitted = 1'b1;
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, output bit emitted,
                             output pixel_beat_t beat);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (tx_burst || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_tga_byte(b, emitted, beat);
        @(negedge aclk);
    endtask

    // drain: all pixels out, then let non-pixel beats clear the internal queue
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // leaves cfg_we high; the caller lowers it
    task automatic write_reg(input logic [tgarle_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tgarle_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == tgarle_pkg::REG_PIXEL_BYTES) begin
            bytes_per_pixel = val;
        end else begin
            rle_on = val[0];
        end
        @(negedge aclk);
    endtask

    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_burst && $urandom_range(0, 4) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
                                                              $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge aclk) begin : check_pixels
        pixel_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel beat %h rep %0d", $time, m_pixel, m_repeat_res);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_pixel !== want.pixel) begin
                    $display("%0t: pixel expected %h actual %h", $time, want.pixel, m_pixel);
                    mismatch_count++;
                end
                if (m_repeat_res !== want.rep) begin
                    $display("%0t: repeat expected %0d actual %0d", $time, want.rep,
                             m_repeat_res);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        bit          emitted;
        pixel_beat_t beat;
        logic [7:0]  b;
        logic [2:0]  size_sel;
        logic        rle_sel;
        int          sent;
        int          phase;
        int          len;
        int          r;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
                cfg_we <= 1'b0;
            end else begin
                send_byte(directed_rows[i].data, emitted, beat);
                if (directed_rows[i].typed) begin
                    beat.pixel = directed_rows[i].exp_pixel;
                    beat.rep = directed_rows[i].exp_rep;
                    pending_pixels.push_back(beat);
                end else if (emitted) begin
                    pending_pixels.push_back(beat);
                end
            end
        end

        sent = 0;
        phase = 0;
        while (sent < 450) begin
            // phases end anywhere, so size and mode changes land mid-pixel and mid-packet
            settle_idle();
            if (phase < 10) begin
                size_sel = size_plan[phase];
                rle_sel = rle_plan[phase];
            end else begin
                size_sel = 3'($urandom_range(0, 7));
                rle_sel = ($urandom_range(0, 3) != 0);
            end
            write_reg(tgarle_pkg::REG_PIXEL_BYTES, size_sel);
            write_reg(tgarle_pkg::REG_RLE_ENABLED, {2'($urandom_range(0, 3)), rle_sel});
            cfg_we <= 1'b0;
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            len = $urandom_range(15, 50);
            repeat (len) begin
                if ($urandom_range(0, 59) == 0) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    while (pending_pixels.size() != 0) @(negedge aclk);
                end
                r = $urandom_range(0, 99);
                if (rle_on && await_header) begin
                    b[7] = $urandom_range(0, 1);
                    b[6:0] = (r < 65) ? 7'($urandom_range(0, 3)) :
                             (r < 90) ? 7'($urandom_range(4, 15)) : 7'($urandom_range(16, 127));
                end else begin
                    b = (r < 8) ? 8'h00 : (r < 16) ? 8'hff : 8'($urandom_range(0, 255));
                end
                send_byte(b, emitted, beat);
                if (emitted) begin
                    pending_pixels.push_back(beat);
                end
                sent++;
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
